// ===== rtl/core/wfm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfm_pkg
// shared constants, codes and types of the word memory with bit-flip faults
// ----------------------------------------------------------------------------
package wfm_pkg;

    localparam int MEM_WORDS   = 1024;
    localparam int FAULT_SLOTS = 8;

    localparam int MEM_AW  = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int FA_W    = $clog2(MEM_WORDS * 4);
    localparam int SLOT_W  = (FAULT_SLOTS > 1) ? $clog2(FAULT_SLOTS) : 1;
    localparam int CNT_W   = $clog2(FAULT_SLOTS + 1);

    localparam int OP_W    = 2;
    localparam int ADDR_W  = 32;
    localparam int DATA_W  = 32;
    localparam int CFG_W   = 13;
    localparam int ENT_W   = 4;

    localparam logic [CFG_W-1:0]  CFG_SIZE_RST = CFG_W'(4096);
    localparam logic [ADDR_W:0]   MEM_BYTES    = (ADDR_W + 1)'(MEM_WORDS * 4);
    localparam logic [ADDR_W:0]   ADDR_STEP    = (ADDR_W + 1)'(4);
    localparam logic [DATA_W-1:0] DATA_ZERO    = '0;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 2'd0,
        OP_READ      = 2'd1,
        OP_ADD_FAULT = 2'd2,
        OP_CLEAR     = 2'd3
    } t_op;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } t_state;

    typedef struct packed {
        logic              add;
        logic              clr;
        logic [FA_W-1:0]   addr;
        logic [DATA_W-1:0] mask;
    } t_flt_req;

    typedef struct packed {
        logic             add_ok;
        logic [CNT_W-1:0] used_next;
    } t_flt_rsp;

endpackage

// ===== rtl/core/wfm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfm_req_if / wfm_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface wfm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] address;
    logic [31:0] data;

    modport source (output valid, operation, address, data, input ready);
    modport sink   (input valid, operation, address, data, output ready);
endinterface

interface wfm_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [31:0] read_data;
    logic [3:0]  fault_entries;

    modport source (output valid, status, read_data, fault_entries, input ready);
    modport sink   (input valid, status, read_data, fault_entries, output ready);
endinterface

// ===== rtl/core/wfm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfm_ram
// single-port-write, single-port-read synchronous ram with registered read data
// ----------------------------------------------------------------------------
module wfm_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/wfm_flt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfm_flt
// bit-flip fault table: append, clear and parallel address match
// ----------------------------------------------------------------------------
module wfm_flt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wfm_pkg::t_flt_req         i_req,
    input  logic [wfm_pkg::FA_W-1:0]  i_look_addr,
    output logic [wfm_pkg::DATA_W-1:0] o_mask,
    output wfm_pkg::t_flt_rsp         o_rsp
);
    import wfm_pkg::*;

    logic [FA_W-1:0]   r_addr [FAULT_SLOTS];
    logic [DATA_W-1:0] r_mask [FAULT_SLOTS];
    logic [CNT_W-1:0]  r_used;
    logic [CNT_W-1:0]  n_used;
    logic              add_ok;

    assign add_ok = i_req.add && (i_req.mask != DATA_ZERO)
                    && (r_used < CNT_W'(FAULT_SLOTS));

    always_comb begin
        n_used = r_used;
        if (i_req.clr) begin
            n_used = '0;
        end else if (add_ok) begin
            n_used = r_used + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (add_ok && !i_req.clr) begin
            r_addr[r_used[SLOT_W-1:0]] <= i_req.addr;
            r_mask[r_used[SLOT_W-1:0]] <= i_req.mask;
        end
    end

    // xor of every held entry matching the lookup address
    always_comb begin
        o_mask = '0;
        for (int i = 0; i < FAULT_SLOTS; i++) begin
            if ((CNT_W'(i) < r_used) && (r_addr[i] == i_look_addr)) begin
                o_mask = o_mask ^ r_mask[i];
            end
        end
    end

    assign o_rsp.add_ok    = add_ok;
    assign o_rsp.used_next = n_used;

endmodule

// ===== rtl/core/word_memory_with_bit_flip_faults_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_memory_with_bit_flip_faults_core
// 32-bit word memory with a bit-flip fault table for fault injection
// ----------------------------------------------------------------------------
// i_req carries one request: write word, read word, add fault or clear
// faults, with a byte address and a data word (write data or xor mask).
// o_rsp returns one result per request: status, read data with matching
// fault masks applied, and the number of fault entries held afterwards.
// i_cfg_we/i_cfg_wdata set the size in bytes; write it only while idle.
// A result goes through stage 1 and the output register before it is valid.
// Throughput: one request per cycle unless o_rsp stalls; the word ram has one
// read and one write port; the fault table is matched in parallel on accept.
// Reset: the fault count clears at once and so empties the table; the word
// ram is then swept to zero, one word per cycle over all MEM_WORDS (1024)
// words, with i_req.ready low. Config writes are taken during the sweep.
// Stall: results sit in an output register and one pipeline stage; when
// o_rsp.ready is low both fill and then i_req.ready drops, nothing is lost.
// ----------------------------------------------------------------------------
module word_memory_with_bit_flip_faults_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [wfm_pkg::CFG_W-1:0]  i_cfg_wdata,
    wfm_req_if.sink                    i_req,
    wfm_rsp_if.source                  o_rsp
);
    import wfm_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [MEM_AW-1:0]  r_clr_idx;
    logic [MEM_AW-1:0]  n_clr_idx;
    logic [CFG_W-1:0]   r_size;

    logic               accept;
    logic               s1_adv;
    logic               in_ready;
    logic               addr_ok;
    logic [ADDR_W:0]    size_ext;
    logic [ADDR_W:0]    limit;
    t_op                op;

    logic               r_s1_vld;
    logic               r_s1_rd;
    logic               r_s1_status;
    logic [DATA_W-1:0]  r_s1_mask;
    logic [CNT_W-1:0]   r_s1_cnt;
    logic               s1_status;

    logic               r_out_vld;
    logic               r_out_status;
    logic [DATA_W-1:0]  r_out_rdata;
    logic [ENT_W-1:0]   r_out_cnt;

    logic               ram_we;
    logic [MEM_AW-1:0]  ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;
    logic [DATA_W-1:0]  ram_q;
    logic [MEM_AW-1:0]  word_idx;

    t_flt_req           flt_req;
    t_flt_rsp           flt_rsp;
    logic [DATA_W-1:0]  flt_mask;

    // size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= CFG_SIZE_RST;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_idx = r_clr_idx + MEM_AW'(1);
                if (r_clr_idx == MEM_AW'(MEM_WORDS - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_clr_idx = r_clr_idx;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // address check
    assign size_ext = (ADDR_W + 1)'(r_size);
    assign limit    = (size_ext > MEM_BYTES) ? MEM_BYTES : size_ext;
    assign addr_ok  = (i_req.address[1:0] == 2'b00) && (r_size != '0)
                      && (({1'b0, i_req.address} + ADDR_STEP) <= limit);

    assign op       = t_op'(i_req.operation);
    assign word_idx = i_req.address[MEM_AW+1:2];

    // handshake
    assign s1_adv   = r_s1_vld && (!r_out_vld || o_rsp.ready);
    assign in_ready = (r_state == ST_RUN) && (!r_s1_vld || s1_adv);
    assign accept   = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    // fault table
    assign flt_req.add  = accept && (op == OP_ADD_FAULT) && addr_ok;
    assign flt_req.clr  = accept && (op == OP_CLEAR);
    assign flt_req.addr = i_req.address[FA_W-1:0];
    assign flt_req.mask = i_req.data;

    wfm_flt u_flt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (flt_req),
        .i_look_addr (i_req.address[FA_W-1:0]),
        .o_mask      (flt_mask),
        .o_rsp       (flt_rsp)
    );

    // word ram
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = word_idx;
        ram_wdata = i_req.data;
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_idx;
            ram_wdata = '0;
        end else if (accept && (op == OP_WRITE) && addr_ok) begin
            ram_we = 1'b1;
        end
    end

    wfm_ram #(
        .DEPTH (MEM_WORDS),
        .WIDTH (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (word_idx),
        .o_rdata (ram_q)
    );

    // status decode
    always_comb begin
        unique case (op)
            OP_WRITE:     s1_status = !addr_ok;
            OP_READ:      s1_status = !addr_ok;
            OP_ADD_FAULT: s1_status = !flt_rsp.add_ok;
            OP_CLEAR:     s1_status = 1'b0;
            default:      s1_status = 1'b1;
        endcase
    end

    // stage 1: waits for ram read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rd     <= (op == OP_READ) && addr_ok;
            r_s1_status <= s1_status;
            r_s1_mask   <= flt_mask;
            r_s1_cnt    <= flt_rsp.used_next;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_status <= r_s1_status;
            r_out_rdata  <= r_s1_rd ? (ram_q ^ r_s1_mask) : '0;
            r_out_cnt    <= ENT_W'(r_s1_cnt);
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.read_data     = r_out_rdata;
    assign o_rsp.fault_entries = r_out_cnt;

endmodule

// ===== rtl/core/wfm_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfm_chk
// port-level checks of the word memory with bit-flip faults
// ----------------------------------------------------------------------------
module wfm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic        i_rsp_status,
    input logic [31:0] i_rsp_read_data,
    input logic [3:0]  i_rsp_fault_entries
);
    import wfm_pkg::*;

    // result held while stalled
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_read_data)
            && $stable(i_rsp_status) && $stable(i_rsp_fault_entries))
        else $error("result changed while stalled");

    // rejected request never carries read data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status |-> i_rsp_read_data == '0)
        else $error("read data on rejected request");

    // fault count bounded by table size
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_fault_entries <= ENT_W'(FAULT_SLOTS))
        else $error("fault count above table size");

    // reset empties the pipe and starts the clearing sweep
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid && !i_req_ready)
        else $error("activity right after reset");

endmodule

bind word_memory_with_bit_flip_faults_core wfm_chk u_wfm_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_status        (o_rsp.status),
    .i_rsp_read_data     (o_rsp.read_data),
    .i_rsp_fault_entries (o_rsp.fault_entries)
);
